// ===== hw/rtl/khr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khr_pkg: shared types and constants for the key hold repeat ramp block
// Widths of the time path, the bit-serial multiply and divide units, input
// kind codes and configuration register indexes.
// ----------------------------------------------------------------------------
package khr_pkg;

    // time and field widths
    localparam int TIME_W    = 32;                 // time stamps, elapsed time
    localparam int CNT_W     = 16;                 // repeat_count
    localparam int RATE_W    = 10;                 // repeat_rate
    localparam int MS_W      = 16;                 // delay_ms, ramp_ms
    localparam int KIND_W    = 2;
    localparam int CFG_W     = 16;                 // widest register
    localparam int CFG_ADDR_W = 2;
    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 24;                 // 17 bits of fields, padded

    // arithmetic unit widths
    localparam int NUM_W     = TIME_W + 12;        // numerator, 2*rate*t + base
    localparam int DEN_W     = 27;                 // 2000 * ramp_ms fits
    localparam int MPL_W     = 16;                 // serial multiplier operand
    localparam int DIV_CNT_W = $clog2(NUM_W + 1);
    localparam int FIRED_W   = 32;

    localparam logic [FIRED_W-1:0] FIRED_CAP = '1; // saturation of totals
    localparam int DEN_UNIT  = 2000;               // 2 * ms per second
    localparam int RAMP_BASE = 15;                 // ramp start rate

    // input kind codes
    localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_DELAY = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RATE  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RAMP  = 2'd2;

    // reset values of the registers
    localparam logic [MS_W-1:0]   DELAY_RST = 16'd300;
    localparam logic [RATE_W-1:0] RATE_RST  = 10'd8;
    localparam logic [MS_W-1:0]   RAMP_RST  = 16'd1000;

    // control into the serial multiplier
    typedef struct packed {
        logic start;     // load operands, begin iterating
        logic acc_clr;   // start from zero instead of the held sum
    } khr_mul_ctrl_t;

endpackage

// ===== hw/rtl/khr_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khr_mul: bit-serial shift-add multiply-accumulate
// One multiplier bit per cycle, LSB first; stops once the remaining
// multiplier bits are all zero.
// ----------------------------------------------------------------------------
module khr_mul (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  khr_pkg::khr_mul_ctrl_t     ctrl,
    input  logic [khr_pkg::NUM_W-1:0]  mcand,
    input  logic [khr_pkg::MPL_W-1:0]  mplier,
    output logic [khr_pkg::NUM_W-1:0]  acc,
    output logic                       done
);
    import khr_pkg::*;

    logic               busy_reg;
    logic [NUM_W-1:0]   mcand_reg;
    logic [MPL_W-1:0]   mplier_reg;
    logic [NUM_W-1:0]   acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (ctrl.start) begin
            busy_reg <= 1'b1;
        end else if (done) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            mcand_reg  <= mcand;
            mplier_reg <= mplier;
            if (ctrl.acc_clr) begin
                acc_reg <= '0;
            end
        end else if (busy_reg && !done) begin
            if (mplier_reg[0]) begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[NUM_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[MPL_W-1:1]};
        end
    end

    assign done = busy_reg && (mplier_reg == '0);
    assign acc  = acc_reg;

endmodule

// ===== hw/rtl/khr_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khr_div: bit-serial restoring divider
// One quotient bit per cycle; quotient bits shift into the numerator
// register as its bits move into the partial remainder.
// ----------------------------------------------------------------------------
module khr_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [khr_pkg::NUM_W-1:0]  num,
    input  logic [khr_pkg::DEN_W-1:0]  den,
    output logic [khr_pkg::NUM_W-1:0]  quot,
    output logic                       done
);
    import khr_pkg::*;

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [DEN_W:0]       trial;
    logic                 q_bit;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign q_bit = (trial >= {1'b0, den_reg});
    assign done  = busy_reg && (cnt_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(NUM_W);
        end else if (done) begin
            busy_reg <= 1'b0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end else if (busy_reg && !done) begin
            if (q_bit) begin
                rem_reg <= DEN_W'(trial - {1'b0, den_reg});
            end else begin
                rem_reg <= trial[DEN_W-1:0];
            end
            num_reg <= {num_reg[NUM_W-2:0], q_bit};
        end
    end

    assign quot = num_reg;

endmodule

// ===== hw/rtl/key_hold_repeat_ramp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_hold_repeat_ramp: typematic key repeat with a linear rate ramp
// Counts key repeats due from press time, delay, rate and ramp settings.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one item per press, tick or release. s_tuser = kind,
//   s_tdata = now_ms. m_ channel: exactly one result item per input item,
//   m_tdata = {pad, key_held, repeat_count}.
//   cfg port: delay_ms (0), repeat_rate (1), ramp_ms (2); write only while
//   the block is idle.
// Sequence (the next item is taken the cycle after the result is registered):
//   Press, release, and ticks that fire nothing pass from decode (and the
//   delay compare) straight to the output register. A tick past the delay
//   runs bit-serial multiplies (one bit per cycle, two or three passes) and
//   a bit-serial divide over the 44-bit numerator.
// Reset:
//   aresetn (sync, active low) restores the register defaults (300 ms,
//   8/s, 1000 ms), releases the key and empties the output register.
// Stall:
//   The result sits in the output register until m_tready; the block may
//   accept the next item meanwhile and holds its own result until the
//   output register frees up.
// ----------------------------------------------------------------------------
module key_hold_repeat_ramp (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_wr_en,
    input  logic [khr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [khr_pkg::CFG_W-1:0]       cfg_wdata,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [khr_pkg::S_DATA_W-1:0]    s_tdata,   // [31:0] now_ms
    input  logic [khr_pkg::KIND_W-1:0]      s_tuser,   // [1:0] kind
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [khr_pkg::M_DATA_W-1:0]    m_tdata    // [15:0] repeat_count,
                                                       // [16] key_held, [23:17] 0
);
    import khr_pkg::*;

    // sequencer states
    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,  // wait for an item
        S_EVAL = 10'b00_0000_0010,  // decode kind, elapsed time
        S_DLY  = 10'b00_0000_0100,  // compare against delay
        S_RAMP = 10'b00_0000_1000,  // pick ramp segment, start first multiply
        S_M1   = 10'b00_0001_0000,  // base term
        S_M2   = 10'b00_0010_0000,  // rate term
        S_M3   = 10'b00_0100_0000,  // ramp: times t
        S_DIV  = 10'b00_1000_0000,  // serial divide
        S_FIN  = 10'b01_0000_0000,  // new repeats versus fired count
        S_OUT  = 10'b10_0000_0000   // hand result to output register
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [MS_W-1:0]    delay_reg;
    logic [RATE_W-1:0]  rate_reg;
    logic [MS_W-1:0]    ramp_ms_reg;

    // architectural state
    logic               held_reg;
    logic [TIME_W-1:0]  press_reg;
    logic [FIRED_W-1:0] fired_reg;

    // per-item work registers
    logic [KIND_W-1:0]  kind_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [TIME_W-1:0]  elapsed_reg;
    logic [TIME_W-1:0]  x_reg;       // t, or t - ramp_ms past the ramp
    logic               short_reg;   // still inside the ramp
    logic [DEN_W-1:0]   den_reg;
    logic [FIRED_W-1:0] total_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               upd_reg;     // tick that moves the fired count

    // output register
    logic               m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    // arithmetic units
    khr_mul_ctrl_t      mul_ctrl;
    logic [NUM_W-1:0]   mul_mcand;
    logic [MPL_W-1:0]   mul_mplier;
    logic [NUM_W-1:0]   mul_acc;
    logic               mul_done;
    logic               div_start;
    logic [NUM_W-1:0]   div_quot;
    logic               div_done;

    // combinational helpers
    logic               ramp_mode;
    logic               in_ramp;
    logic               q_sat;
    logic [FIRED_W-1:0] total_calc;
    logic [FIRED_W-1:0] fired_diff;
    logic               out_free;
    logic               held_out;

    khr_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mul_ctrl),
        .mcand   (mul_mcand),
        .mplier  (mul_mplier),
        .acc     (mul_acc),
        .done    (mul_done)
    );

    // numerator goes straight from the multiply accumulator
    khr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (mul_acc),
        .den     (den_reg),
        .quot    (div_quot),
        .done    (div_done)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ramp applies only when it has length and the rate climbs above 15/s
    assign ramp_mode = (ramp_ms_reg != '0) && (rate_reg > RATE_W'(RAMP_BASE));
    assign in_ramp   = ramp_mode && (x_reg < TIME_W'(ramp_ms_reg));

    // total = 1 + due, saturated
    assign q_sat      = (|div_quot[NUM_W-1:FIRED_W]) || (&div_quot[FIRED_W-1:0]);
    assign total_calc = q_sat ? FIRED_CAP : div_quot[FIRED_W-1:0] + 1'b1;
    assign fired_diff = total_reg - fired_reg;

    always_comb begin
        unique case (kind_reg)
            KIND_PRESS:   held_out = 1'b1;
            KIND_RELEASE: held_out = 1'b0;
            default:      held_out = held_reg;
        endcase
    end

    // -------------------------------------------------------------------
    // Sequencer and unit operand selection.
    //   flat:        N = 2*rate*t,                          D = 2000
    //   past ramp:   N = R*(rate+15) + 2*rate*(t-R),        D = 2000
    //   in ramp:     N = t*(2*R*15 + (rate-15)*t),          D = 2000*R
    // -------------------------------------------------------------------
    always_comb begin
        state_next       = state_reg;
        mul_ctrl.start   = 1'b0;
        mul_ctrl.acc_clr = 1'b0;
        mul_mcand        = '0;
        mul_mplier       = '0;
        div_start        = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                if (kind_reg == KIND_TICK && held_reg && rate_reg != '0) begin
                    state_next = S_DLY;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_DLY: begin
                if (elapsed_reg < TIME_W'(delay_reg)) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_RAMP;
                end
            end
            S_RAMP: begin
                // first term: 2*R*15 in ramp, R*(rate+15) past it, none if flat
                mul_ctrl.start   = 1'b1;
                mul_ctrl.acc_clr = 1'b1;
                if (in_ramp) begin
                    mul_mcand  = NUM_W'({ramp_ms_reg, 1'b0});
                    mul_mplier = MPL_W'(RAMP_BASE);
                end else if (ramp_mode) begin
                    mul_mcand  = NUM_W'(ramp_ms_reg);
                    mul_mplier = MPL_W'(rate_reg) + MPL_W'(RAMP_BASE);
                end
                state_next = S_M1;
            end
            S_M1: begin
                if (mul_done) begin
                    mul_ctrl.start = 1'b1;
                    if (short_reg) begin
                        mul_mcand  = NUM_W'(x_reg);
                        mul_mplier = MPL_W'(rate_reg) - MPL_W'(RAMP_BASE);
                    end else begin
                        mul_mcand  = NUM_W'({x_reg, 1'b0});
                        mul_mplier = MPL_W'(rate_reg);
                    end
                    state_next = S_M2;
                end
            end
            S_M2: begin
                if (mul_done) begin
                    if (short_reg) begin
                        mul_ctrl.start   = 1'b1;
                        mul_ctrl.acc_clr = 1'b1;
                        mul_mcand        = mul_acc;
                        mul_mplier       = x_reg[MPL_W-1:0];
                        state_next       = S_M3;
                    end else begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_M3: begin
                if (mul_done) begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // per-item datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                kind_reg <= s_tuser;
                now_reg  <= s_tdata[TIME_W-1:0];
            end
            S_EVAL: begin
                elapsed_reg <= now_reg - press_reg;
                upd_reg     <= 1'b0;
                cnt_reg     <= (kind_reg == KIND_PRESS && !held_reg) ? CNT_W'(1) : '0;
            end
            S_DLY: begin
                x_reg <= elapsed_reg - TIME_W'(delay_reg);
            end
            S_RAMP: begin
                short_reg <= in_ramp;
                if (ramp_mode && !in_ramp) begin
                    x_reg <= x_reg - TIME_W'(ramp_ms_reg);
                end
                if (in_ramp) begin
                    den_reg <= DEN_W'(ramp_ms_reg) * DEN_W'(DEN_UNIT);
                end else begin
                    den_reg <= DEN_W'(DEN_UNIT);
                end
            end
            S_DIV: begin
                total_reg <= total_calc;
            end
            S_FIN: begin
                upd_reg <= 1'b1;
                // wrapped elapsed time can leave the total below the fired count
                if (total_reg > fired_reg) begin
                    cnt_reg <= (|fired_diff[FIRED_W-1:CNT_W]) ? '1
                                                              : fired_diff[CNT_W-1:0];
                end else begin
                    cnt_reg <= '0;
                end
            end
            default: begin
            end
        endcase
    end

    // key state, updated when the result is handed over
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg  <= 1'b0;
            press_reg <= '0;
            fired_reg <= '0;
        end else if (state_reg == S_OUT && out_free) begin
            held_reg <= held_out;
            unique case (kind_reg)
                KIND_PRESS: begin
                    if (!held_reg) begin
                        press_reg <= now_reg;
                        fired_reg <= '0;
                    end
                end
                KIND_TICK: begin
                    if (upd_reg) begin
                        fired_reg <= total_reg;
                    end
                end
                KIND_RELEASE: begin
                    press_reg <= '0;
                    fired_reg <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_OUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_OUT && out_free) begin
            m_data_reg <= M_DATA_W'({held_out, cnt_reg});
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg   <= DELAY_RST;
            rate_reg    <= RATE_RST;
            ramp_ms_reg <= RAMP_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_DELAY: delay_reg   <= cfg_wdata[MS_W-1:0];
                REG_RATE:  rate_reg    <= cfg_wdata[RATE_W-1:0];
                REG_RAMP:  ramp_ms_reg <= cfg_wdata[MS_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== tb/khr_repeat_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khr_repeat_checker: result predictor and comparator for key_hold_repeat_ramp
// Snoops the register port and both streams. Each accepted input item is run
// through a cycle-free model of the repeat logic. Each accepted result is
// compared with the oldest prediction. Counters go back to the top level.
// ----------------------------------------------------------------------------
module khr_repeat_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [khr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [khr_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [khr_pkg::S_DATA_W-1:0]    s_tdata,   // [31:0] now_ms
    input  logic [khr_pkg::KIND_W-1:0]      s_tuser,   // [1:0] kind
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [khr_pkg::M_DATA_W-1:0]    m_tdata,   // [15:0] repeat_count,
                                                       // [16] key_held, [23:17] 0
    output int unsigned                     items_in,
    output int unsigned                     items_out,
    output int unsigned                     mismatches,
    output int unsigned                     fired_ticks,
    output int unsigned                     capped_ticks
);
    import khr_pkg::*;

    localparam logic [63:0] TOTAL_CAP  = 64'hFFFF_FFFF;
    localparam int          MAX_PRINTS = 50;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             held;
    } repeat_result_t;

    // register copies
    logic [MS_W-1:0]    delay_q;
    logic [RATE_W-1:0]  rate_q;
    logic [MS_W-1:0]    ramp_q;
    // hold state
    logic               held_q;
    logic [TIME_W-1:0]  press_q;
    logic [FIRED_W-1:0] fired_q;

    repeat_result_t     pending_results[$];

    // repeats due t ms past the delay, not counting the first one
    function automatic logic [63:0] repeats_due(input logic [63:0] t);
        logic [63:0] rate, r0, span, q, r, extra, v;
        rate = 64'(rate_q);
        r0   = (rate < RAMP_BASE) ? rate : RAMP_BASE;
        span = 64'(ramp_q);
        if (span != 0 && rate > r0) begin
            if (t < span)
                return (2 * span * r0 * t + (rate - r0) * t * t) / (DEN_UNIT * span);
            q     = (t - span) / 1000;
            r     = (t - span) % 1000;
            extra = ((rate + r0) * span + 2 * rate * r) / DEN_UNIT;
        end else begin
            q     = t / 1000;
            r     = t % 1000;
            extra = (r * rate) / 1000;
        end
        v = q * rate + extra;
        return (v > TOTAL_CAP) ? TOTAL_CAP : v;
    endfunction

    function automatic logic [CNT_W-1:0] tick_repeats(input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] held_for;
        logic [63:0]       total, n;
        if (!held_q)
            return '0;
        held_for = now - press_q;   // wraps mod 2^32
        if (held_for < delay_q || rate_q == 0)
            return '0;
        total   = repeats_due(64'(held_for) - 64'(delay_q));
        total   = (total >= TOTAL_CAP) ? TOTAL_CAP : total + 1;
        n       = (total > 64'(fired_q)) ? total - 64'(fired_q) : 64'd0;
        fired_q = total[FIRED_W-1:0];   // taken even when it went down
        return (n > 64'hFFFF) ? '1 : n[CNT_W-1:0];
    endfunction

    function automatic repeat_result_t next_repeat_result(input logic [KIND_W-1:0] kind,
                                                          input logic [TIME_W-1:0] now);
        repeat_result_t res;
        res.count = '0;
        case (kind)
            KIND_PRESS: begin
                if (!held_q) begin
                    held_q    = 1'b1;
                    press_q   = now;
                    fired_q   = '0;
                    res.count = CNT_W'(1);
                end
            end
            KIND_TICK: begin
                res.count = tick_repeats(now);
            end
            KIND_RELEASE: begin
                held_q  = 1'b0;
                press_q = '0;
                fired_q = '0;
            end
            default: ;
        endcase
        res.held = held_q;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("[%0t] result %0d %s: got 0x%0h, expected 0x%0h",
                     $time, items_out, what, got, want);
    endtask

    // posedge sampling: DUT flops update in the NBA region, so this sees
    // the values the handshake was judged on
    always @(posedge aclk) begin : watch
        repeat_result_t want;
        if (!aresetn) begin
            delay_q      = DELAY_RST;
            rate_q       = RATE_RST;
            ramp_q       = RAMP_RST;
            held_q       = 1'b0;
            press_q      = '0;
            fired_q      = '0;
            items_in     = 0;
            items_out    = 0;
            mismatches   = 0;
            fired_ticks  = 0;
            capped_ticks = 0;
            pending_results.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_DELAY: delay_q = cfg_wdata[MS_W-1:0];
                    REG_RATE:  rate_q  = cfg_wdata[RATE_W-1:0];
                    REG_RAMP:  ramp_q  = cfg_wdata[MS_W-1:0];
                    default: ;
                endcase
            end
            // compare before predicting, so a stray result never meets
            // the prediction for an item taken at this same edge
            if (m_tvalid && m_tready) begin
                items_out++;
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", 32'(m_tdata), 32'd0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_tdata[CNT_W-1:0] != want.count)
                        report_mismatch("repeat_count", 32'(m_tdata[CNT_W-1:0]),
                                        32'(want.count));
                    if (m_tdata[CNT_W] != want.held)
                        report_mismatch("key_held", 32'(m_tdata[CNT_W]), 32'(want.held));
                    if (m_tdata[M_DATA_W-1:CNT_W+1] != '0)
                        report_mismatch("padding", 32'(m_tdata[M_DATA_W-1:CNT_W+1]), 32'd0);
                end
            end
            if (s_tvalid && s_tready) begin
                want = next_repeat_result(s_tuser, s_tdata[TIME_W-1:0]);
                pending_results.push_back(want);
                items_in++;
                if (s_tuser == KIND_TICK && want.count != 0)
                    fired_ticks++;
                if (want.count == '1)
                    capped_ticks++;
            end
        end
    end

endmodule

// ===== tb/key_hold_repeat_ramp_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_hold_repeat_ramp_tb: stimulus and verdict for the key repeat block
// A directed opening hits the corner cases of press, tick and release; then
// random hold sequences (press, rising ticks, release) plus noise run under a
// dozen register settings, with random gaps and back-pressure on both streams.
// The checker beside the DUT predicts and compares every result item.
// ----------------------------------------------------------------------------
module key_hold_repeat_ramp_tb;
    import khr_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;  // ignored by the block

    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 132;
    localparam int MAX_IDLE        = 18;
    localparam int DRAIN_CYCLES    = 200;   // well past the slowest tick
    localparam int HALF_PERIOD     = 10;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_W-1:0]       cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata;    // [31:0] now_ms
    logic [KIND_W-1:0]      s_tuser;    // [1:0] kind
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_DATA_W-1:0]    m_tdata;    // [15:0] repeat_count, [16] key_held, [23:17] 0

    // from the checker; all of them move only on rising edges
    int unsigned items_in;
    int unsigned items_out;
    int unsigned mismatches;
    int unsigned fired_ticks;
    int unsigned capped_ticks;

    // pacing: a steady side never idles (set per phase)
    bit          src_steady;
    bit          sink_steady;
    int unsigned sent;
    int unsigned settings_run;
    // current register values, used to scale tick spacing
    int unsigned delay_now;
    int unsigned ramp_now;

    key_hold_repeat_ramp dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    khr_repeat_checker repeat_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .items_in     (items_in),
        .items_out    (items_out),
        .mismatches   (mismatches),
        .fired_ticks  (fired_ticks),
        .capped_ticks (capped_ticks)
    );

    // 20 ns clock
    initial begin
        aclk = 1'b0;
        forever #HALF_PERIOD aclk = ~aclk;
    end

    // hard stop in case a handshake never comes
    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Result side: draw a stall per item, then hold tready until the item
    // is taken. Acceptance is seen through the checker's counter, which is
    // stable at the falling edge.
    initial begin : result_sink
        int          stall;
        int unsigned seen;
        m_tready = 1'b0;
        forever begin
            stall = sink_steady ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            seen = items_out;
            m_tready <= 1'b1;
            do @(negedge aclk); while (items_out == seen);
        end
    end

    // Offer one item after a random gap; returns at the falling edge right
    // after it was taken, with tvalid still high.
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [TIME_W-1:0] now);
        int          gap;
        int unsigned target;
        gap = src_steady ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= now;
        target = items_in + 1;
        do @(negedge aclk); while (items_in != target);
        sent++;
    endtask

    // drop tvalid and let every result come back: block is idle afterwards
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (items_out != items_in) @(negedge aclk);
    endtask

    // all three registers, back to back, only once the block is idle
    task automatic write_settings(input logic [MS_W-1:0] delay, input logic [RATE_W-1:0] rate,
                                  input logic [MS_W-1:0] ramp);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_DELAY;
        cfg_wdata <= delay;
        @(negedge aclk);
        cfg_addr  <= REG_RATE;
        cfg_wdata <= CFG_W'(rate);
        @(negedge aclk);
        cfg_addr  <= REG_RAMP;
        cfg_wdata <= ramp;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        delay_now = delay;
        ramp_now  = ramp;
        settings_run++;
    endtask

    // spacing between ticks: mostly near the delay and ramp scale, sometimes
    // huge jumps or time running backward (elapsed time wraps)
    function automatic logic [TIME_W-1:0] hold_step();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 35) return $urandom_range(0, 200);
        if (pick < 60) return $urandom_range(0, 3000);
        if (pick < 85) return $urandom_range(0, delay_now + 2 * ramp_now + 2000);
        if (pick < 95) return $urandom_range(0, 2_000_000);
        if (pick < 98) return -$urandom_range(1, 5000);
        return $urandom;
    endfunction

    // well-formed hold: press, rising ticks, then mostly a release
    task automatic run_hold_sequence();
        logic [TIME_W-1:0] start;
        logic [TIME_W-1:0] now;
        int                ticks;
        start = $urandom;
        now   = start;
        send_item(KIND_PRESS, now);
        ticks = $urandom_range(1, 12);
        for (int i = 0; i < ticks; i++) begin
            // sometimes land right on the delay boundary
            if (i == 0 && $urandom_range(0, 2) == 0)
                now = start + delay_now + $urandom_range(0, 2);
            else
                now = now + hold_step();
            send_item(KIND_TICK, now);
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: send_item(KIND_RELEASE, $urandom);
            6:                send_item(KIND_PRESS, now + $urandom_range(0, 100));
            default: ;      // stays held into the next sequence
        endcase
    endtask

    initial begin : stimulus
        int unsigned phase_start;
        aresetn    = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_addr   = REG_DELAY;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = KIND_PRESS;
        src_steady  = 1'b0;
        sink_steady = 1'b0;
        sent         = 0;
        settings_run = 1;           // the reset values count as one
        delay_now    = DELAY_RST;
        ramp_now     = RAMP_RST;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // --- directed part, reset registers: 300 ms delay, 8/s, 1000 ms ramp
        send_item(KIND_RELEASE, 32'hFFFF_FFFF);        // release with nothing held
        send_item(KIND_TICK, 32'd0);                   // tick with nothing held
        send_item(KIND_UNUSED, 32'h5555_5555);         // unknown kind
        send_item(KIND_PRESS, 32'hFFFF_FF00);
        send_item(KIND_PRESS, 32'hAAAA_AAAA);          // press while held
        send_item(KIND_TICK, 32'hFFFF_FF00 + 299);     // 1 ms short of the delay
        send_item(KIND_TICK, 32'hFFFF_FF00 + 300);     // first repeat, clock wraps
        send_item(KIND_TICK, 32'hFFFF_FF00 + 900);     // inside the ramp
        send_item(KIND_TICK, 32'hFFFF_FF00 + 1300);    // ramp end
        send_item(KIND_TICK, 32'hFFFF_FF00 + 9300);    // full rate
        send_item(KIND_UNUSED, 32'd0);                 // unknown kind while held
        send_item(KIND_TICK, 32'hFFFF_FEFF);           // elapsed wraps to max: capped
        send_item(KIND_TICK, 32'hFFFF_FF00 + 9400);    // total falls below fired
        send_item(KIND_RELEASE, 32'd0);

        // no delay, top rate, flat
        write_settings(16'd0, 10'd1023, 16'd0);
        send_item(KIND_PRESS, 32'd0);
        send_item(KIND_TICK, 32'd0);                   // first repeat at once
        send_item(KIND_TICK, 32'hFFFF_FFFF);           // 32-bit total saturates
        send_item(KIND_RELEASE, 32'h1234_5678);

        // longest delay and ramp, rate zero: never repeats
        write_settings(16'hFFFF, 10'd0, 16'hFFFF);
        send_item(KIND_PRESS, 32'd1234);
        send_item(KIND_TICK, 32'd1234 + 70000);
        send_item(KIND_RELEASE, 32'd0);

        // --- random part
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: write_settings(16'd0, 10'd1000, 16'hFFFF);
                1: write_settings(16'hFFFF, 10'd1, 16'd0);
                2: write_settings(16'd40, 10'd15, 16'd500);    // ramp set, rate at base
                3: write_settings(16'd0, 10'd1023, 16'd1);
                4: write_settings(16'd300, 10'd16, 16'hFFFF);
                5: write_settings(16'd25, 10'd0, 16'd2000);
                default: write_settings(MS_W'($urandom_range(0, 700)),
                                        RATE_W'($urandom_range(1, 1023)),
                                        MS_W'(($urandom_range(0, 3) == 0) ? 0 :
                                              $urandom_range(1, 5000)));
            endcase
            // one phase in four runs both sides flat out
            src_steady  = (p % 4 == 1) || (p % 4 == 3);
            sink_steady = (p % 4 == 2) || (p % 4 == 3);
            phase_start = sent;
            while (sent - phase_start < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 6) == 0)
                    send_item(KIND_W'($urandom_range(0, 3)), $urandom);   // noise
                else
                    run_hold_sequence();
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge aclk);   // catch stray results

        $display("Checked %0d result items over %0d register settings, random gaps and stalls.",
                 items_out, settings_run);
        $display("%0d ticks fired repeats, %0d results hit the 16-bit count cap.",
                 fired_ticks, capped_ticks);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
